// File: design/skl3d_pkg.sv
// ----------------------------------------------------------------------------
// skl3d_pkg
// Shared widths and constants for the skew line distance pipeline.
// ----------------------------------------------------------------------------
package skl3d_pkg;

    localparam int DIR_FRAC_BITS = 14;
    localparam int TOL_SHIFT     = 2 * DIR_FRAC_BITS;

    localparam int ROOT_W  = 32;
    localparam int DIR_W   = 16;
    localparam int TOL_W   = 16;
    localparam int DIST_W  = 32;
    localparam int NUM_W   = 130;
    localparam int DEN_W   = 64;

    // cross product index pairs: component i = x[NXT]*y[PRV] - x[PRV]*y[NXT]
    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

endpackage

// File: design/skl3d_geom.sv
// ----------------------------------------------------------------------------
// skl3d_geom
// Seven-stage front end: cross products, determinant, projections and the
// numerator / denominator pair handed to the root pipeline.
// ----------------------------------------------------------------------------
module skl3d_geom (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic signed [skl3d_pkg::ROOT_W-1:0]  i_a_root [3],
    input  logic signed [skl3d_pkg::DIR_W-1:0]   i_a_dir  [3],
    input  logic signed [skl3d_pkg::ROOT_W-1:0]  i_b_root [3],
    input  logic signed [skl3d_pkg::DIR_W-1:0]   i_b_dir  [3],
    input  logic        [skl3d_pkg::TOL_W-1:0]   i_tol,
    output logic                                 o_vld,
    output logic        [skl3d_pkg::NUM_W-1:0]   o_num,
    output logic        [skl3d_pkg::DEN_W-1:0]   o_den,
    output logic                                 o_par
);
    import skl3d_pkg::*;

    logic [7:1] r_vld;

    // stage 1
    logic signed [32:0] r1_d  [3];
    logic signed [15:0] r1_v  [3];
    logic signed [31:0] r1_pa [3];
    logic signed [31:0] r1_pb [3];
    logic        [30:0] r1_vsq [3];
    // stage 2
    logic signed [32:0] r2_d  [3];
    logic signed [31:0] r2_w  [3];
    logic        [31:0] r2_vv;
    logic signed [48:0] r2_ea [3];
    logic signed [48:0] r2_eb [3];
    // stage 3
    logic signed [63:0] r3_wsq [3];
    logic signed [64:0] r3_dw  [3];
    logic        [48:0] r3_em  [3];
    logic signed [65:0] r3_dsq [3];
    logic        [31:0] r3_vv;
    // stage 4
    logic        [63:0] r4_det;
    logic signed [66:0] r4_acc;
    logic        [49:0] r4_hh [3];
    logic        [48:0] r4_hl [3];
    logic        [47:0] r4_ll [3];
    logic        [66:0] r4_dsq;
    logic        [31:0] r4_vv;
    // stage 5
    logic               r5_par;
    logic        [63:0] r5_det;
    logic        [64:0] r5_accm;
    logic        [96:0] r5_esq [3];
    logic        [66:0] r5_dsq;
    logic        [31:0] r5_vv;
    // stage 6
    logic               r6_par;
    logic        [63:0] r6_det;
    logic        [97:0] r6_enum;
    logic        [63:0] r6_hh;
    logic        [64:0] r6_hl;
    logic        [65:0] r6_ll;
    logic        [66:0] r6_dsq;
    logic        [31:0] r6_vv;
    // stage 7
    logic               r7_par;
    logic [NUM_W-1:0]   r7_num;
    logic [DEN_W-1:0]   r7_den;

    logic signed [49:0] w3_ed [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w3_ed[i] = 50'(r2_ea[i]) - 50'(r2_eb[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:1], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_d[i]   <= 33'(i_a_root[i]) - 33'(i_b_root[i]);
            r1_v[i]   <= i_b_dir[i];
            r1_pa[i]  <= i_a_dir[NXT[i]] * i_b_dir[PRV[i]];
            r1_pb[i]  <= i_a_dir[PRV[i]] * i_b_dir[NXT[i]];
            r1_vsq[i] <= 31'($unsigned(32'(i_b_dir[i] * i_b_dir[i])));
        end

        for (int i = 0; i < 3; i++) begin
            r2_d[i]  <= r1_d[i];
            r2_w[i]  <= r1_pa[i] - r1_pb[i];
            r2_ea[i] <= r1_d[NXT[i]] * 49'(r1_v[PRV[i]]);
            r2_eb[i] <= r1_d[PRV[i]] * 49'(r1_v[NXT[i]]);
        end
        r2_vv <= 32'(r1_vsq[0]) + 32'(r1_vsq[1]) + 32'(r1_vsq[2]);

        for (int i = 0; i < 3; i++) begin
            r3_wsq[i] <= 64'(r2_w[i]) * 64'(r2_w[i]);
            r3_dw[i]  <= 65'(r2_d[i]) * 65'(r2_w[i]);
            r3_em[i]  <= w3_ed[i][49] ? 49'(-w3_ed[i]) : 49'(w3_ed[i]);
            r3_dsq[i] <= 66'(r2_d[i]) * 66'(r2_d[i]);
        end
        r3_vv <= r2_vv;

        r4_det <= 64'($unsigned(r3_wsq[0])) + 64'($unsigned(r3_wsq[1]))
                + 64'($unsigned(r3_wsq[2]));
        r4_acc <= 67'(r3_dw[0]) + 67'(r3_dw[1]) + 67'(r3_dw[2]);
        for (int i = 0; i < 3; i++) begin
            r4_hh[i] <= 50'(r3_em[i][48:24]) * 50'(r3_em[i][48:24]);
            r4_hl[i] <= 49'(r3_em[i][48:24]) * 49'(r3_em[i][23:0]);
            r4_ll[i] <= 48'(r3_em[i][23:0]) * 48'(r3_em[i][23:0]);
        end
        r4_dsq <= 67'($unsigned(r3_dsq[0])) + 67'($unsigned(r3_dsq[1]))
                + 67'($unsigned(r3_dsq[2]));
        r4_vv  <= r3_vv;

        // exact compare against tolerance scaled to determinant units
        r5_par  <= r4_det <= (64'(i_tol) << TOL_SHIFT);
        r5_det  <= r4_det;
        r5_accm <= r4_acc[66] ? 65'(-r4_acc) : 65'(r4_acc);
        for (int i = 0; i < 3; i++) begin
            r5_esq[i] <= (97'(r4_hh[i]) << 48) + (97'(r4_hl[i]) << 25) + 97'(r4_ll[i]);
        end
        r5_dsq <= r4_dsq;
        r5_vv  <= r4_vv;

        r6_par  <= r5_par;
        r6_det  <= r5_det;
        r6_enum <= 98'(r5_esq[0]) + 98'(r5_esq[1]) + 98'(r5_esq[2]);
        r6_hh   <= 64'(r5_accm[64:33]) * 64'(r5_accm[64:33]);
        r6_hl   <= 65'(r5_accm[64:33]) * 65'(r5_accm[32:0]);
        r6_ll   <= 66'(r5_accm[32:0]) * 66'(r5_accm[32:0]);
        r6_dsq  <= r5_dsq;
        r6_vv   <= r5_vv;

        // parallel: distance from root a to line b, or root to root when v is zero
        r7_par <= r6_par;
        if (!r6_par) begin
            r7_num <= (NUM_W'(r6_hh) << 66) + (NUM_W'(r6_hl) << 34) + NUM_W'(r6_ll);
            r7_den <= r6_det;
        end else if (r6_vv == '0) begin
            r7_num <= NUM_W'(r6_dsq);
            r7_den <= DEN_W'(1);
        end else begin
            r7_num <= NUM_W'(r6_enum);
            r7_den <= DEN_W'(r6_vv);
        end
    end

    assign o_vld = r_vld[7];
    assign o_num = r7_num;
    assign o_den = r7_den;
    assign o_par = r7_par;

endmodule

// File: design/skl3d_root.sv
// ----------------------------------------------------------------------------
// skl3d_root
// Pipelined restoring root of num/den: one quotient bit per stage, the
// trial square tracked by running remainder and q*den, no multipliers.
// ----------------------------------------------------------------------------
module skl3d_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [skl3d_pkg::NUM_W-1:0]         i_num,
    input  logic [skl3d_pkg::DEN_W-1:0]         i_den,
    input  logic                                i_par,
    output logic                                o_vld,
    output logic [skl3d_pkg::DIST_W-1:0]        o_q,
    output logic                                o_par
);
    import skl3d_pkg::*;

    localparam int QW = DIST_W;
    localparam int CW = NUM_W + 1;
    localparam int RW = DEN_W + QW;

    logic             r_vld [QW];
    logic [NUM_W-1:0] r_rem [QW];
    logic [RW-1:0]    r_rq  [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic             r_par [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;

        logic             s_vld;
        logic [NUM_W-1:0] s_rem;
        logic [RW-1:0]    s_rq;
        logic [QW-1:0]    s_q;
        logic [DEN_W-1:0] s_den;
        logic             s_par;
        logic [CW-1:0]    trial;
        logic [CW:0]      diff;

        if (k == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_rem = i_num;
            assign s_rq  = '0;
            assign s_q   = '0;
            assign s_den = i_den;
            assign s_par = i_par;
        end else begin : g_next
            assign s_vld = r_vld[k-1];
            assign s_rem = r_rem[k-1];
            assign s_rq  = r_rq[k-1];
            assign s_q   = r_q[k-1];
            assign s_den = r_den[k-1];
            assign s_par = r_par[k-1];
        end

        // (q + 2^B)^2 * den - q^2 * den
        assign trial = (CW'(s_rq) << (B + 1)) + (CW'(s_den) << (2 * B));
        assign diff  = (CW + 1)'(s_rem) - (CW + 1)'(trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[k] <= s_den;
            r_par[k] <= s_par;
            if (!diff[CW]) begin
                r_rem[k] <= diff[NUM_W-1:0];
                r_rq[k]  <= s_rq + (RW'(s_den) << B);
                r_q[k]   <= s_q | (QW'(1) << B);
            end else begin
                r_rem[k] <= s_rem;
                r_rq[k]  <= s_rq;
                r_q[k]   <= s_q;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_q   = r_q[QW-1];
    assign o_par = r_par[QW-1];

endmodule

// File: design/skew_line_distance_3d.sv
// A start transfer passes 7 geometry stages, then one stage per distance bit
// in the 32-stage root pipeline, before its result strobes.
// Throughput: one line pair per cycle; busy stays low, start is always taken.
// Reset (synchronous, active low) flushes all items in flight and sets the
// parallel tolerance to 16.
// ----------------------------------------------------------------------------
// skew_line_distance_3d
// Shortest distance between two 3D lines, with a parallel-line fallback.
// ----------------------------------------------------------------------------
module skew_line_distance_3d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic signed [31:0]  i_line_a_root_x,
    input  logic signed [31:0]  i_line_a_root_y,
    input  logic signed [31:0]  i_line_a_root_z,
    input  logic signed [15:0]  i_line_a_dir_x,
    input  logic signed [15:0]  i_line_a_dir_y,
    input  logic signed [15:0]  i_line_a_dir_z,
    input  logic signed [31:0]  i_line_b_root_x,
    input  logic signed [31:0]  i_line_b_root_y,
    input  logic signed [31:0]  i_line_b_root_z,
    input  logic signed [15:0]  i_line_b_dir_x,
    input  logic signed [15:0]  i_line_b_dir_y,
    input  logic signed [15:0]  i_line_b_dir_z,
    output logic                o_strobe,
    output logic [31:0]         o_line_distance,
    output logic                o_lines_parallel
);
    import skl3d_pkg::*;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd16;

    logic [TOL_W-1:0]        r_tol;
    logic signed [ROOT_W-1:0] w_a_root [3];
    logic signed [DIR_W-1:0]  w_a_dir  [3];
    logic signed [ROOT_W-1:0] w_b_root [3];
    logic signed [DIR_W-1:0]  w_b_dir  [3];
    logic                     w_take;
    logic                     w_g_vld;
    logic [NUM_W-1:0]         w_num;
    logic [DEN_W-1:0]         w_den;
    logic                     w_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    assign busy   = 1'b0;
    assign w_take = start && !busy;

    assign w_a_root = '{i_line_a_root_x, i_line_a_root_y, i_line_a_root_z};
    assign w_a_dir  = '{i_line_a_dir_x, i_line_a_dir_y, i_line_a_dir_z};
    assign w_b_root = '{i_line_b_root_x, i_line_b_root_y, i_line_b_root_z};
    assign w_b_dir  = '{i_line_b_dir_x, i_line_b_dir_y, i_line_b_dir_z};

    skl3d_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_take),
        .i_a_root (w_a_root),
        .i_a_dir  (w_a_dir),
        .i_b_root (w_b_root),
        .i_b_dir  (w_b_dir),
        .i_tol    (r_tol),
        .o_vld    (w_g_vld),
        .o_num    (w_num),
        .o_den    (w_den),
        .o_par    (w_par)
    );

    skl3d_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_g_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_par   (w_par),
        .o_vld   (o_strobe),
        .o_q     (o_line_distance),
        .o_par   (o_lines_parallel)
    );

    a_strobe_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_take, 39))
        else $error("result strobe without a matching start transfer");

    a_start_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> ##39 o_strobe)
        else $error("start transfer lost in the pipeline");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_g_vld |-> w_den != '0)
        else $error("root pipeline fed a zero denominator");

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks skew_line_distance_3d against an exact wide-integer predictor.
// Line pairs are sent through the start/busy handshake with random gaps.
// Every strobed result is compared with the oldest outstanding prediction.
// The parallel tolerance is swept through several values, extremes included.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import skl3d_pkg::*;

    localparam int LATENCY      = 39;
    localparam int SETTLE       = LATENCY + 8;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_ITEMS = 500;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              parallel;
    } distance_t;

    class distance_scoreboard;
        distance_t      pending[$];
        logic [15:0]    tolerance;
        int             mismatches;
        int             checked;
        int             parallel_seen;

        function new();
            tolerance = 16'd16;
        endfunction

        function automatic wide_t magnitude(wide_t x);
            return (x < 0) ? -x : x;
        endfunction

        // floor(sqrt(num/den)), saturated to 32 bits
        function automatic logic [31:0] root_of_ratio(wide_t num, wide_t den);
            logic [31:0] q;
            wide_t       c;
            q = '0;
            for (int b = 31; b >= 0; b--) begin
                c = wide_t'(q | (32'd1 << b));
                if (c * c * den <= num) q = c[31:0];
            end
            return q;
        endfunction

        function void note(logic [2:0][31:0] ar, logic [2:0][31:0] br,
                           logic [2:0][15:0] ad, logic [2:0][15:0] bd);
            wide_t     d[3], u[3], v[3], w[3];
            wide_t     det, acc, num, vv, cr, limit;
            distance_t e;
            for (int i = 0; i < 3; i++) begin
                d[i] = wide_t'($signed(ar[i])) - wide_t'($signed(br[i]));
                u[i] = wide_t'($signed(ad[i]));
                v[i] = wide_t'($signed(bd[i]));
            end
            for (int i = 0; i < 3; i++)
                w[i] = u[NXT[i]] * v[PRV[i]] - u[PRV[i]] * v[NXT[i]];
            det = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
            limit = wide_t'({240'd0, tolerance}) <<< TOL_SHIFT;
            e.parallel = (det <= limit);
            if (!e.parallel) begin
                acc = d[0] * w[0] + d[1] * w[1] + d[2] * w[2];
                num = magnitude(acc) * magnitude(acc);
                e.distance = root_of_ratio(num, det);
            end else begin
                vv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
                if (vv == 0) begin
                    num = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
                    e.distance = root_of_ratio(num, 1);
                end else begin
                    num = 0;
                    for (int i = 0; i < 3; i++) begin
                        cr = d[NXT[i]] * v[PRV[i]] - d[PRV[i]] * v[NXT[i]];
                        num = num + cr * cr;
                    end
                    e.distance = root_of_ratio(num, vv);
                end
            end
            pending.push_back(e);
        endfunction

        task report(string what);
            $display("%0t: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check(logic [31:0] distance, logic parallel);
            distance_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result %h par %b", distance, parallel));
                return;
            end
            e = pending.pop_front();
            checked++;
            if (parallel) parallel_seen++;
            if (distance !== e.distance)
                report($sformatf("distance %h, predicted %h", distance, e.distance));
            if (parallel !== e.parallel)
                report($sformatf("parallel flag %b, predicted %b", parallel, e.parallel));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_cfg_we;
    logic [15:0]       i_cfg_wdata;
    logic [2:0][31:0]  root_a, root_b;
    logic [2:0][15:0]  dir_a, dir_b;
    logic              o_strobe;
    logic [31:0]       o_line_distance;
    logic              o_lines_parallel;

    distance_scoreboard sb;
    int                 idle_cycles;
    int                 sent;

    skew_line_distance_3d dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_line_a_root_x  (root_a[0]),
        .i_line_a_root_y  (root_a[1]),
        .i_line_a_root_z  (root_a[2]),
        .i_line_a_dir_x   (dir_a[0]),
        .i_line_a_dir_y   (dir_a[1]),
        .i_line_a_dir_z   (dir_a[2]),
        .i_line_b_root_x  (root_b[0]),
        .i_line_b_root_y  (root_b[1]),
        .i_line_b_root_z  (root_b[2]),
        .i_line_b_dir_x   (dir_b[0]),
        .i_line_b_dir_y   (dir_b[1]),
        .i_line_b_dir_z   (dir_b[2]),
        .o_strobe         (o_strobe),
        .o_line_distance  (o_line_distance),
        .o_lines_parallel (o_lines_parallel)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check(o_line_distance, o_lines_parallel);
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    function automatic logic [31:0] pick_root();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed(($urandom() & 32'h000F_FFFF)) - 32'sh0008_0000);
            default: return 32'($signed(($urandom() & 32'h03FF_FFFF)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
            default: return 16'($urandom_range(0, 32768)) - 16'd16384;
        endcase
    endfunction

    task send_pair(input logic [2:0][31:0] ar, input logic [2:0][31:0] br,
                   input logic [2:0][15:0] ad, input logic [2:0][15:0] bd,
                   input int gap);
        root_a <= ar;
        root_b <= br;
        dir_a  <= ad;
        dir_b  <= bd;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(ar, br, ad, bd);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_random();
        logic [2:0][31:0] ar, br;
        logic [2:0][15:0] ad, bd;
        int               mode;
        for (int i = 0; i < 3; i++) begin
            ar[i] = pick_root();
            br[i] = pick_root();
            ad[i] = pick_dir();
            bd[i] = pick_dir();
        end
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            bd = ad;
        end else if (mode == 1) begin
            for (int i = 0; i < 3; i++) bd[i] = -$signed(ad[i]);
        end else if (mode == 2) begin
            // nearly parallel: nudge each component a little
            for (int i = 0; i < 3; i++)
                bd[i] = ad[i] + 16'($urandom_range(0, 6)) - 16'd3;
        end else if (mode == 3) begin
            if ($urandom_range(0, 1)) ad = '0; else bd = '0;
        end
        send_pair(ar, br, ad, bd, pick_gap());
    endtask

    // hold off the sender until every result is back and the pipe is empty
    task drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task write_tolerance(input logic [15:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.tolerance = value;
    endtask

    task run_directed();
        logic [2:0][31:0] z32;
        logic [2:0][15:0] ex, ey, ez, zd;
        z32 = '0;
        zd  = '0;
        ex  = {16'sd0, 16'sd0, 16'sd16384};
        ey  = {16'sd0, 16'sd16384, 16'sd0};
        ez  = {16'sd16384, 16'sd0, 16'sd0};
        // skew axes one unit apart in z
        send_pair(z32, {32'h0001_0000, 32'd0, 32'd0}, ex, ey, 0);
        send_pair(z32, {32'h0003_8000, 32'h0001_0000, 32'h0000_2000}, ex, ey, 1);
        // parallel and antiparallel lines
        send_pair(z32, {32'd0, 32'h0002_0000, 32'd0}, ex, ex, 0);
        send_pair({32'h0001_0000, 32'd0, 32'd5}, z32, ez, {-16'sd16384, 16'sd0, 16'sd0}, 2);
        // zero first direction, zero second, both zero
        send_pair({32'h0000_4000, 32'h0001_0000, 32'd0}, z32, zd, ey, 0);
        send_pair({32'h0003_0000, 32'h0004_0000, 32'd0}, z32, ex, zd, 0);
        send_pair({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                  {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, zd, zd, 0);
        // saturation: roots at opposite extremes, skew
        send_pair({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
                  {32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, ex, ey, 0);
        // direction extremes and non-unit patterns
        send_pair(z32, {32'h0000_1000, 32'd7, 32'hFFFF_0000},
                  {-16'sd16384, -16'sd16384, -16'sd16384},
                  {16'sd16384, -16'sd16384, 16'sd16384}, 3);
        send_pair({32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF}, z32,
                  {16'h7FFF, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h0001}, 0);
        // tiny cross product right around the default tolerance
        send_pair(z32, {32'h0001_0000, 32'd0, 32'd0}, ex, {16'sd0, 16'sd4, 16'sd16384}, 0);
        send_pair(z32, {32'h0001_0000, 32'd0, 32'd0}, ex, {16'sd0, 16'sd5, 16'sd16384}, 0);
        send_pair(z32, {32'h0001_0000, 32'd0, 32'd0}, ex, {16'sd0, 16'sd1, 16'sd16384}, 0);
        send_pair({32'hFFFF_FFFF, 32'd1, 32'h8000_0000}, {32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
                  ey, ez, 40);
    endtask

    initial begin
        logic [15:0] tol_plan[5];
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        root_a      = '0;
        root_b      = '0;
        dir_a       = '0;
        dir_b       = '0;
        sent        = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        tol_plan = '{16'd0, 16'hFFFF, 16'($urandom()), 16'd1, 16'd16};
        foreach (tol_plan[p]) begin
            write_tolerance(tol_plan[p]);
            if (p == 1) run_directed();
            repeat (RANDOM_ITEMS / 5) send_random();
        end

        drain();
        $display("sent %0d line pairs, checked %0d results (%0d parallel)",
                 sent, sb.checked, sb.parallel_seen);
        $display("tolerance swept over 16, 0, 65535, a random value and 1");
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: sim.f
design/skl3d_pkg.sv
design/skl3d_geom.sv
design/skl3d_root.sv
design/skew_line_distance_3d.sv
test/testbench.sv
